FILE: rtl/core/utf8v_pkg.sv
// Byte-pattern constants for the UTF-8 stream validator.
// No dependencies; the validator core uses these by scoped name.
package utf8v_pkg;

  localparam logic [7:0] AsciiLimit   = 8'h80;
  localparam logic [7:0] Mask3        = 8'hE0;
  localparam logic [7:0] Mask2        = 8'hC0;
  localparam logic [7:0] Mask7        = 8'hFE;
  localparam logic [7:0] Mask4        = 8'hF0;
  localparam logic [7:0] Mask5        = 8'hF8;
  localparam logic [7:0] ContMark     = 8'h80;
  localparam logic [7:0] Lead2Mark    = 8'hC0;
  localparam logic [7:0] Lead3Mark    = 8'hE0;
  localparam logic [7:0] Lead4Mark    = 8'hF0;
  localparam logic [7:0] LeadSurr     = 8'hED;
  localparam logic [7:0] LeadNonchar  = 8'hEF;
  localparam logic [7:0] LeadMax      = 8'hF4;
  localparam logic [7:0] SurrRange    = 8'hA0;
  localparam logic [7:0] NoncharMid   = 8'hBF;
  localparam logic [7:0] NoncharLast  = 8'hBE;
  localparam logic [7:0] ContMaxF4    = 8'h8F;

  typedef logic [1:0] seq_count_t;

endpackage

FILE: rtl/core/utf8_stream_validator_unit.sv
// UTF-8 stream validator: one byte per word, verdict on the last byte.
// Depends on utf8v_pkg for byte-pattern constants and the count type.

// A string arrives one byte per word on the byte channel, its final byte
// flagged by last_byte; exactly one word with string_valid leaves on the
// result channel per string, after its last byte. A byte is taken every
// cycle while the input register can move on: each one passes from an
// input register through the sequence decoder into the state and result
// registers; the verdict is registered as its last byte leaves the input
// register. Only a last byte waits on a stalled result register.
module utf8_stream_validator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       string_valid
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;
  logic       take_in;

  // Sequence state.
  utf8v_pkg::seq_count_t cont_left, cont_left_next;
  utf8v_pkg::seq_count_t pos, pos_next;
  logic [7:0] lead, lead_next;
  logic       nc_seen, nc_seen_next;
  logic       err, err_next;
  logic       byte_ok;
  logic       verdict;

  // A last byte needs a free result register; other bytes always move on.
  assign s1_adv     = s1_valid && (!s1_last || !result_valid || !result_stall);
  assign byte_stall = s1_valid && !s1_adv;
  assign take_in    = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (take_in) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_comb begin
    cont_left_next = cont_left;
    pos_next       = pos;
    lead_next      = lead;
    nc_seen_next   = nc_seen;
    byte_ok        = 1'b1;
    if (cont_left == 2'd0) begin
      // Lead byte.
      if (s1_byte < utf8v_pkg::AsciiLimit) begin
        byte_ok = 1'b1;
      end else if ((s1_byte & utf8v_pkg::Mask3) == utf8v_pkg::Lead2Mark) begin
        if ((s1_byte & utf8v_pkg::Mask7) == utf8v_pkg::Lead2Mark) begin
          byte_ok = 1'b0;
        end
        cont_left_next = 2'd1;
      end else if ((s1_byte & utf8v_pkg::Mask4) == utf8v_pkg::Lead3Mark) begin
        cont_left_next = 2'd2;
      end else if ((s1_byte & utf8v_pkg::Mask5) == utf8v_pkg::Lead4Mark) begin
        if (s1_byte > utf8v_pkg::LeadMax) begin
          byte_ok = 1'b0;
        end
        cont_left_next = 2'd3;
      end else begin
        byte_ok = 1'b0;
      end
      if (s1_byte >= utf8v_pkg::AsciiLimit) begin
        lead_next    = s1_byte;
        pos_next     = 2'd0;
        nc_seen_next = 1'b0;
      end
    end else begin
      // Continuation byte.
      if ((s1_byte & utf8v_pkg::Mask2) != utf8v_pkg::ContMark) begin
        byte_ok = 1'b0;
      end
      if (pos == 2'd0) begin
        if (lead == utf8v_pkg::Lead3Mark &&
            (s1_byte & utf8v_pkg::Mask3) == utf8v_pkg::ContMark) begin
          byte_ok = 1'b0;
        end
        if (lead == utf8v_pkg::LeadSurr &&
            (s1_byte & utf8v_pkg::Mask3) == utf8v_pkg::SurrRange) begin
          byte_ok = 1'b0;
        end
        if (lead == utf8v_pkg::Lead4Mark &&
            (s1_byte & utf8v_pkg::Mask4) == utf8v_pkg::ContMark) begin
          byte_ok = 1'b0;
        end
        if (lead == utf8v_pkg::LeadMax && s1_byte > utf8v_pkg::ContMaxF4) begin
          byte_ok = 1'b0;
        end
        nc_seen_next = (lead == utf8v_pkg::LeadNonchar) &&
                       (s1_byte == utf8v_pkg::NoncharMid);
      end else if (pos == 2'd1) begin
        if (lead == utf8v_pkg::LeadNonchar && nc_seen &&
            (s1_byte & utf8v_pkg::Mask7) == utf8v_pkg::NoncharLast) begin
          byte_ok = 1'b0;
        end
        nc_seen_next = 1'b0;
      end
      pos_next       = pos + 2'd1;
      cont_left_next = cont_left - 2'd1;
      if (cont_left_next == 2'd0) begin
        pos_next     = 2'd0;
        lead_next    = 8'd0;
        nc_seen_next = 1'b0;
      end
    end
    err_next = err;
    if (!byte_ok) begin
      err_next       = 1'b1;
      cont_left_next = 2'd0;
      pos_next       = 2'd0;
      lead_next      = 8'd0;
      nc_seen_next   = 1'b0;
    end
  end

  // A sequence cut off by the last byte counts as invalid.
  assign verdict = !err_next && (cont_left_next == 2'd0);

  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_last)) begin
      cont_left <= 2'd0;
      pos       <= 2'd0;
      lead      <= 8'd0;
      nc_seen   <= 1'b0;
      err       <= 1'b0;
    end else if (s1_adv) begin
      cont_left <= cont_left_next;
      pos       <= pos_next;
      lead      <= lead_next;
      nc_seen   <= nc_seen_next;
      err       <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (s1_adv && s1_last) begin
      string_valid <= verdict;
    end
  end

  // A verdict word only ever follows a last byte leaving the input register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_adv && s1_last))
    else $error("result word without a last byte");

  // The end of a string returns the sequence state to its reset value.
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst && s1_adv && s1_last) |->
      (cont_left == 2'd0 && !err && lead == 8'd0 && pos == 2'd0))
    else $error("state not cleared after last byte");

  // An open sequence always has a multi-byte lead recorded.
  assert property (@(posedge clk) disable iff (rst)
    (cont_left != 2'd0) |-> (lead[7:6] == 2'b11))
    else $error("open sequence without a lead byte");

  // Outside a sequence the position and noncharacter tracking are idle.
  assert property (@(posedge clk) disable iff (rst)
    (cont_left == 2'd0) |-> (pos == 2'd0 && !nc_seen))
    else $error("stale sequence tracking");

  // A byte is never held back while the result register can take a verdict.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !result_valid) |-> !byte_stall)
    else $error("input held with a free result register");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for utf8_stream_validator_unit: directed and random byte strings,
// checked against a byte-level UTF-8 tracker. Needs utf8v_pkg and the RTL.
module tb_top;

  localparam int RandomBytes = 1200;
  localparam int PhaseOneAt  = 400;
  localparam int PhaseTwoAt  = 800;
  localparam int HoldAt      = 250;
  localparam int HoldLen     = 250;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 200000;

  typedef struct packed {
    logic       hold;
    logic       fin;
    logic [7:0] b;
  } byte_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       string_valid;

  byte_item_t pending[$];
  byte_item_t next_item;
  logic [7:0] build_q[$];
  logic       verdicts_due[$];

  // Tracker state for the string in flight.
  utf8v_pkg::seq_count_t conts_left;
  utf8v_pkg::seq_count_t conts_taken;
  logic [7:0] lead_q;
  logic       ef_bf_seen;
  logic       fault_q;

  int bytes_taken = 0;
  int bytes_queued = 0;
  int strings_sent = 0;
  int verdicts_checked = 0;
  int bad_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  utf8_stream_validator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .string_valid (string_valid)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("tb_top: MISMATCH at cycle %0d: %s", cycle_count, what);
    bad_count++;
  endtask

  task automatic clear_tracker();
    conts_left  = '0;
    conts_taken = '0;
    lead_q      = 8'h00;
    ef_bf_seen  = 1'b0;
  endtask

  // Advances the tracker by one accepted byte and queues a verdict on the
  // last byte of a string.
  task automatic track_byte(input logic [7:0] b, input logic fin);
    logic ok;
    ok = 1'b1;
    if (conts_left == 0) begin
      if (b < utf8v_pkg::AsciiLimit) begin
        ok = 1'b1;
      end else if ((b & utf8v_pkg::Mask3) == utf8v_pkg::Lead2Mark) begin
        ok = ((b & utf8v_pkg::Mask7) != utf8v_pkg::Lead2Mark);
        if (ok) conts_left = 2'd1;
      end else if ((b & utf8v_pkg::Mask4) == utf8v_pkg::Lead3Mark) begin
        conts_left = 2'd2;
      end else if ((b & utf8v_pkg::Mask5) == utf8v_pkg::Lead4Mark) begin
        ok = (b <= utf8v_pkg::LeadMax);
        if (ok) conts_left = 2'd3;
      end else begin
        ok = 1'b0;
      end
      if (ok && b >= utf8v_pkg::AsciiLimit) begin
        lead_q      = b;
        conts_taken = '0;
        ef_bf_seen  = 1'b0;
      end
    end else begin
      if ((b & utf8v_pkg::Mask2) != utf8v_pkg::ContMark) begin
        ok = 1'b0;
      end else if (conts_taken == 0) begin
        if (lead_q == utf8v_pkg::Lead3Mark &&
            (b & utf8v_pkg::Mask3) == utf8v_pkg::ContMark) ok = 1'b0;
        if (lead_q == utf8v_pkg::LeadSurr &&
            (b & utf8v_pkg::Mask3) == utf8v_pkg::SurrRange) ok = 1'b0;
        if (lead_q == utf8v_pkg::Lead4Mark &&
            (b & utf8v_pkg::Mask4) == utf8v_pkg::ContMark) ok = 1'b0;
        if (lead_q == utf8v_pkg::LeadMax && b > utf8v_pkg::ContMaxF4) ok = 1'b0;
        ef_bf_seen = (lead_q == utf8v_pkg::LeadNonchar && b == utf8v_pkg::NoncharMid);
      end else if (conts_taken == 1) begin
        if (lead_q == utf8v_pkg::LeadNonchar && ef_bf_seen &&
            (b & utf8v_pkg::Mask7) == utf8v_pkg::NoncharLast) ok = 1'b0;
        ef_bf_seen = 1'b0;
      end
      if (ok) begin
        conts_taken = conts_taken + 2'd1;
        conts_left  = conts_left - 2'd1;
        if (conts_left == 0) clear_tracker();
      end
    end
    if (!ok) begin
      fault_q = 1'b1;
      clear_tracker();
    end
    if (fin) begin
      verdicts_due.push_back(!fault_q && conts_left == 0);
      clear_tracker();
      fault_q = 1'b0;
    end
  endtask

  function automatic int send_idle_pct();
    if (bytes_taken < PhaseOneAt) return 9;
    if (bytes_taken < PhaseTwoAt) return 60;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (bytes_taken < PhaseOneAt) return 60;
    if (bytes_taken < PhaseTwoAt) return 9;
    return 0;
  endfunction

  function automatic logic [7:0] rand_cont();
    logic [7:0] c;
    c = 8'($urandom_range(8'h80, 8'hBF));
    return c;
  endfunction

  // Moves the bytes in build_q to the pending queue as one string.
  task automatic flush_string(input logic hold);
    for (int i = 0; i < build_q.size(); i++) begin
      pending.push_back('{hold: (hold && i == 0), fin: (i == build_q.size() - 1),
                          b: build_q[i]});
    end
    bytes_queued += build_q.size();
    strings_sent++;
    build_q.delete();
  endtask

  // Directed string of up to four bytes, first byte in the top position.
  task automatic queue_string(input logic [31:0] bytes, input int count);
    for (int i = 0; i < count; i++) build_q.push_back(bytes[8*(count-1-i) +: 8]);
    flush_string(1'b0);
  endtask

  task automatic add_code_point();
    int         kind;
    logic [7:0] lead;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        lead = 8'($urandom_range(0, 127));
        build_q.push_back(lead);
      end
      3, 4: begin
        if ($urandom_range(0, 9) == 0) lead = 8'($urandom_range(8'hC0, 8'hC1));
        else lead = 8'($urandom_range(8'hC2, 8'hDF));
        build_q.push_back(lead);
        build_q.push_back(rand_cont());
      end
      5, 6: begin
        case ($urandom_range(0, 4))
          0: lead = utf8v_pkg::Lead3Mark;
          1: lead = utf8v_pkg::LeadSurr;
          2, 3: lead = utf8v_pkg::LeadNonchar;
          default: lead = 8'($urandom_range(8'hE1, 8'hEF));
        endcase
        build_q.push_back(lead);
        if (lead == utf8v_pkg::LeadNonchar && $urandom_range(0, 1) == 1) begin
          // Land on or next to the two noncharacters.
          build_q.push_back(utf8v_pkg::NoncharMid);
          lead = 8'($urandom_range(8'hBC, 8'hBF));
          build_q.push_back(lead);
        end else begin
          build_q.push_back(rand_cont());
          build_q.push_back(rand_cont());
        end
      end
      7, 8: begin
        case ($urandom_range(0, 6))
          0, 1: lead = utf8v_pkg::Lead4Mark;
          2, 3: lead = utf8v_pkg::LeadMax;
          4, 5: lead = 8'($urandom_range(8'hF1, 8'hF3));
          default: lead = 8'($urandom_range(8'hF5, 8'hFF));
        endcase
        build_q.push_back(lead);
        for (int i = 0; i < 3; i++) build_q.push_back(rand_cont());
      end
      default: begin
        lead = 8'($urandom_range(0, 255));
        build_q.push_back(lead);
      end
    endcase
  endtask

  task automatic add_random_string(input logic hold);
    int         n;
    int         pos;
    logic [7:0] junk;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) add_code_point();
    case ($urandom_range(0, 19))
      0: if (build_q.size() > 1) void'(build_q.pop_back());
      1: begin
        pos = $urandom_range(0, build_q.size() - 1);
        junk = 8'($urandom_range(0, 255));
        build_q[pos] = junk;
      end
      default: ;
    endcase
    flush_string(hold);
  endtask

  // Sender: offers the next pending word, holding it steady while stalled.
  always @(posedge clk) begin
    if (rst) begin
      byte_valid  <= 1'b0;
      data_byte   <= 8'h00;
      last_byte   <= 1'b0;
      bytes_taken <= 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        track_byte(data_byte, last_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!byte_valid || !byte_stall) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct() &&
            !(pending[0].hold && verdicts_due.size() != 0)) begin
          next_item = pending.pop_front();
          data_byte  <= next_item.b;
          last_byte  <= next_item.fin;
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold that backs up the input.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && bytes_taken >= HoldAt) begin
      hold_done    <= 1'b1;
      hold_left    <= HoldLen;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("verdict %0b with no string pending", string_valid));
      end else begin
        if (string_valid !== verdicts_due[0]) begin
          report_mismatch($sformatf("string_valid %0b, expected %0b",
                                    string_valid, verdicts_due[0]));
        end
        void'(verdicts_due.pop_front());
        verdicts_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    clear_tracker();
    fault_q = 1'b0;

    queue_string(32'h00, 1);            // lowest ASCII
    queue_string(32'h7F, 1);            // highest ASCII
    queue_string(32'h80, 1);            // stray continuation
    queue_string(32'hC080, 2);          // overlong two-byte lead
    queue_string(32'hC280, 2);          // smallest valid two-byte form
    queue_string(32'hE09F, 2);          // overlong three-byte form
    queue_string(32'hE0A080, 3);        // smallest valid three-byte form
    queue_string(32'hEDA0, 2);          // surrogate
    queue_string(32'hF08F, 2);          // overlong four-byte form
    queue_string(32'hF490, 2);          // above U+10FFFF
    queue_string(32'hEFBFBE, 3);        // noncharacter
    queue_string(32'hFF, 1);            // lead that can never start a sequence
    queue_string(32'hC2, 1);            // sequence cut off by the last byte
    queue_string(32'hF48FBFBF, 4);      // highest code point

    add_random_string(1'b1);
    while (bytes_queued < RandomBytes) add_random_string($urandom_range(0, 29) == 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || byte_valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    end

    $display("tb_top: %0d bytes in %0d strings, %0d verdicts checked", bytes_taken,
             strings_sent, verdicts_checked);
    $display("tb_top: covered mixed idling, a long result hold and sender pauses");
    if (bad_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/utf8v_pkg.sv
rtl/core/utf8_stream_validator_unit.sv
dv/tb_top.sv
